// File: sv/tlgl_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes for the text line glyph layout block.
// No dependencies; every other file of the block except tlgl_ram imports this package.
package tlgl_pkg;

  // Table and pen geometry.
  localparam int LINE_WIDTH  = 320;
  localparam int GLYPH_SLOTS = 128;
  localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
  localparam int PEN_W       = 11;
  localparam int GW_W        = 8;
  localparam int SUM_W       = PEN_W + 1;

  localparam logic [PEN_W-1:0] PEN_MAX   = {PEN_W{1'b1}};
  localparam logic [SUM_W-1:0] LINE_LIM  = SUM_W'(LINE_WIDTH);
  localparam logic [PEN_W-1:0] BLANK_STEP = PEN_W'(4);
  localparam logic [PEN_W-1:0] LINE_STEP  = PEN_W'(8);

  // Tab stop every 80 columns: quotient by multiply with reciprocal.
  localparam logic [PEN_W-1:0] TAB_RECIP = PEN_W'(1639);
  localparam int               TAB_SHIFT = 17;
  localparam int               TAB_Q_W   = 2 * PEN_W - TAB_SHIFT;

  // Character codes.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CH_CASE    = 8'h20;
  localparam logic [7:0] CH_LAST    = 8'h7F;
  localparam logic [6:0] CH_CURSOR  = 7'h5F;

  // Request types.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_CHAR  = 2'd2;
  localparam logic [1:0] REQ_END   = 2'd3;

  // Command kinds passed from the front end to the back end.
  localparam logic [2:0] K_START   = 3'd0;
  localparam logic [2:0] K_END     = 3'd1;
  localparam logic [2:0] K_NEWLINE = 3'd2;
  localparam logic [2:0] K_TAB     = 3'd3;
  localparam logic [2:0] K_ESC     = 3'd4;
  localparam logic [2:0] K_GLYPH   = 3'd5;
  localparam logic [2:0] K_BLANK   = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FIRST_GLYPH = 2'd0;
  localparam logic [1:0] CFG_CURSOR_COL  = 2'd1;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [GW_W-1:0]   width;
    logic              digit_ok;
    logic [3:0]        digit;
    logic [9:0]        start_x;
    logic [10:0]       start_y;
    logic [3:0]        color;
    logic              want_cursor;
  } cmd_t;

  typedef struct packed {
    logic [PEN_W-1:0]  draw_x;
    logic [PEN_W-1:0]  draw_y;
    logic [6:0]        glyph_slot;
    logic [3:0]        draw_color;
    logic              is_cursor;
  } draw_t;

endpackage

// File: sv/tlgl_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tlgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds when re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/tlgl_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, writes the glyph width table, classifies
// characters and reads glyph widths. Uses tlgl_pkg and tlgl_ram.
module tlgl_front
  import tlgl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        req_type,
  input  logic [6:0]        table_slot,
  input  logic [7:0]        slot_width,
  input  logic [7:0]        char_code,
  input  logic [9:0]        start_x,
  input  logic [10:0]       start_y,
  input  logic [3:0]        line_color,
  input  logic              want_cursor,
  input  logic [6:0]        first_glyph,
  output logic              cmd_push,
  output cmd_t              cmd,
  input  logic              cmd_full
);

  logic              accept;
  logic [7:0]        cu;
  logic [6:0]        idx;
  logic [2:0]        kind;
  logic              ram_we;
  logic              ram_re;
  logic [GW_W-1:0]   ram_rdata;
  logic              s1_valid_r, s1_valid_nxt;
  cmd_t              s1_r;
  cmd_t              s1_nxt;

  assign full     = s1_valid_r && cmd_full;
  assign accept   = push && !full;
  assign cmd_push = s1_valid_r && !cmd_full;

  // Upper-case a..z, then classify the byte.
  always_comb begin
    cu = char_code;
    if (char_code >= CH_LOW_A && char_code <= CH_LOW_Z) begin
      cu = char_code - CH_CASE;
    end
    kind = K_BLANK;
    idx  = cu[6:0] - first_glyph;
    unique case (req_type)
      REQ_START: kind = K_START;
      REQ_END: begin
        kind = K_END;
        idx  = CH_CURSOR - first_glyph;
      end
      REQ_CHAR, REQ_LOAD: begin
        if (cu == CH_NEWLINE) begin
          kind = K_NEWLINE;
        end else if (cu == CH_TAB) begin
          kind = K_TAB;
        end else if (cu == CH_ESC) begin
          kind = K_ESC;
        end else if (cu != CH_SPACE && cu >= {1'b0, first_glyph} && cu <= CH_LAST) begin
          kind = K_GLYPH;
        end else begin
          kind = K_BLANK;
        end
      end
      default: kind = K_BLANK;
    endcase
  end

  // Glyph width table: loads write, characters and line ends read.
  assign ram_we = accept && (req_type == REQ_LOAD) && (32'(table_slot) < GLYPH_SLOTS);
  assign ram_re = accept && (req_type == REQ_CHAR || req_type == REQ_END);

  tlgl_ram #(
    .WIDTH (GW_W),
    .DEPTH (GLYPH_SLOTS)
  ) u_width_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (table_slot[SLOT_W-1:0]),
    .wdata (slot_width),
    .re    (ram_re),
    .raddr (idx[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  // Decode stage register, waiting for the table read to complete.
  always_comb begin
    s1_nxt             = s1_r;
    s1_valid_nxt       = s1_valid_r && !cmd_push;
    if (accept && req_type != REQ_LOAD) begin
      s1_valid_nxt       = 1'b1;
      s1_nxt.kind        = kind;
      s1_nxt.slot        = idx[SLOT_W-1:0];
      s1_nxt.width       = '0;
      s1_nxt.digit_ok    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
      s1_nxt.digit       = char_code[3:0];
      s1_nxt.start_x     = start_x;
      s1_nxt.start_y     = start_y;
      s1_nxt.color       = line_color;
      s1_nxt.want_cursor = want_cursor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_r <= s1_nxt;
  end

  // Attach the width read when the command entered the decode register.
  always_comb begin
    cmd       = s1_r;
    cmd.width = ram_rdata;
  end

endmodule

// File: sv/tlgl_cmdq.sv
`timescale 1ns / 1ps
// Four-entry command queue between the front end and the back end.
// Uses tlgl_pkg for the command type.
module tlgl_cmdq
  import tlgl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rdata
);

  localparam int QD = 4;
  localparam int QA = $clog2(QD);

  cmd_t          ent_r [QD];
  logic [QA-1:0] wp_r, wp_nxt;
  logic [QA-1:0] rp_r, rp_nxt;
  logic [QA:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QA+1)'(QD));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rp_r];

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QA+1)'(push) - (QA+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

endmodule

// File: sv/tlgl_back.sv
`timescale 1ns / 1ps
// Back end: keeps the pen, colour and line state, executes commands and
// queues draw transactions. Uses tlgl_pkg.
module tlgl_back
  import tlgl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_empty,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic [3:0] cursor_color,
  output logic       out_empty,
  input  logic       out_pop,
  output draw_t      out_draw
);

  logic [PEN_W-1:0]     pen_x_r, pen_x_nxt;
  logic [PEN_W-1:0]     pen_y_r, pen_y_nxt;
  logic [3:0]           color_r, color_nxt;
  logic                 esc_r, esc_nxt;
  logic                 stop_r, stop_nxt;

  logic [SUM_W-1:0]     x_plus_w;
  logic [SUM_W-1:0]     x_plus_b;
  logic [SUM_W-1:0]     y_plus_l;
  logic [2*PEN_W-1:0]   tab_prod;
  logic [TAB_Q_W:0]     tab_q1;
  logic [SUM_W-1:0]     tab_next;
  logic [PEN_W-1:0]     x_glyph, x_blank, x_tab, y_line;

  logic                 emit;
  draw_t                res;

  // Result queue, two entries.
  draw_t                rq_r [2];
  logic                 rq_wp_r, rq_rp_r;
  logic [1:0]           rq_cnt_r;
  logic                 rq_full;

  assign rq_full   = (rq_cnt_r == 2'd2);
  assign out_empty = (rq_cnt_r == 2'd0);
  assign out_draw  = rq_r[rq_rp_r];
  assign cmd_pop   = !cmd_empty && !rq_full;

  // Pen arithmetic with saturation.
  always_comb begin
    x_plus_w = {1'b0, pen_x_r} + SUM_W'(cmd.width);
    x_plus_b = {1'b0, pen_x_r} + {1'b0, BLANK_STEP};
    y_plus_l = {1'b0, pen_y_r} + {1'b0, LINE_STEP};
    tab_prod = pen_x_r * TAB_RECIP;
    tab_q1   = {1'b0, tab_prod[2*PEN_W-1:TAB_SHIFT]} + 1'b1;
    tab_next = (SUM_W'(tab_q1) << 6) + (SUM_W'(tab_q1) << 4);
    x_glyph  = (x_plus_w > {1'b0, PEN_MAX}) ? PEN_MAX : x_plus_w[PEN_W-1:0];
    x_blank  = (x_plus_b > {1'b0, PEN_MAX}) ? PEN_MAX : x_plus_b[PEN_W-1:0];
    x_tab    = (tab_next > {1'b0, PEN_MAX}) ? PEN_MAX : tab_next[PEN_W-1:0];
    y_line   = (y_plus_l > {1'b0, PEN_MAX}) ? PEN_MAX : y_plus_l[PEN_W-1:0];
  end

  // Command execution.
  always_comb begin
    pen_x_nxt      = pen_x_r;
    pen_y_nxt      = pen_y_r;
    color_nxt      = color_r;
    esc_nxt        = esc_r;
    stop_nxt       = stop_r;
    emit           = 1'b0;
    res.draw_x     = pen_x_r;
    res.draw_y     = pen_y_r;
    res.glyph_slot = 7'(cmd.slot);
    res.draw_color = color_r;
    res.is_cursor  = 1'b0;
    if (cmd_pop) begin
      if (cmd.kind == K_START) begin
        pen_x_nxt = PEN_W'(cmd.start_x);
        pen_y_nxt = cmd.start_y;
        color_nxt = cmd.color;
        esc_nxt   = 1'b0;
        stop_nxt  = 1'b0;
      end else if (cmd.kind == K_END) begin
        esc_nxt = 1'b0;
        if (cmd.want_cursor && x_plus_w <= LINE_LIM) begin
          emit           = 1'b1;
          res.draw_color = cursor_color;
          res.is_cursor  = 1'b1;
        end
      end else if (stop_r) begin
        // Stopped line: characters are dropped until the next line start.
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        if (cmd.digit_ok) begin
          color_nxt = cmd.digit;
        end
      end else begin
        unique case (cmd.kind)
          K_NEWLINE: begin
            pen_x_nxt = '0;
            pen_y_nxt = y_line;
          end
          K_TAB: pen_x_nxt = x_tab;
          K_ESC: esc_nxt = 1'b1;
          K_GLYPH: begin
            if (x_plus_w > LINE_LIM) begin
              stop_nxt = 1'b1;
            end else begin
              emit      = 1'b1;
              pen_x_nxt = x_glyph;
            end
          end
          default: begin
            pen_x_nxt = x_blank;
            if ({1'b0, x_blank} >= LINE_LIM) begin
              stop_nxt = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r  <= '0;
      pen_y_r  <= '0;
      color_r  <= '0;
      esc_r    <= 1'b0;
      stop_r   <= 1'b0;
      rq_wp_r  <= 1'b0;
      rq_rp_r  <= 1'b0;
      rq_cnt_r <= '0;
    end else begin
      pen_x_r  <= pen_x_nxt;
      pen_y_r  <= pen_y_nxt;
      color_r  <= color_nxt;
      esc_r    <= esc_nxt;
      stop_r   <= stop_nxt;
      rq_wp_r  <= rq_wp_r ^ emit;
      rq_rp_r  <= rq_rp_r ^ (out_pop && !out_empty);
      rq_cnt_r <= rq_cnt_r + 2'(emit) - 2'(out_pop && !out_empty);
    end
    if (emit) begin
      rq_r[rq_wp_r] <= res;
    end
  end

endmodule

// File: sv/text_line_glyph_layout.sv
`timescale 1ns / 1ps
// Top level of the text line glyph layout block: configuration registers
// and the front end, command queue and back end. Uses tlgl_pkg.
//
//  channel   ports                         accepted when
//  input     in_push / in_full, in_*       in_push && !in_full
//  result    out_empty / out_pop, out_*    out_pop && !out_empty
//  config    cfg_valid / cfg_ready         cfg_valid && cfg_ready
//
// One item per cycle sustained while the result side keeps popping. A character
// passes the decode register, where the glyph width table is read, then the
// head of the command queue, where the back end updates the pen with one add
// and compare, then the result queue before it is on the result ports.
// rst_n is synchronous; it empties both queues and clears the pen state.
// The glyph width table is not cleared. A stalled result side fills the
// result and command queues, then raises in_full.
module text_line_glyph_layout
  import tlgl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_req_type,
  input  logic [6:0]  in_table_slot,
  input  logic [7:0]  in_slot_width,
  input  logic [7:0]  in_char_code,
  input  logic [9:0]  in_start_x,
  input  logic [10:0] in_start_y,
  input  logic [3:0]  in_line_color,
  input  logic        in_want_cursor,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [10:0] out_draw_x,
  output logic [10:0] out_draw_y,
  output logic [6:0]  out_glyph_slot,
  output logic [3:0]  out_draw_color,
  output logic        out_is_cursor,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [6:0] first_glyph_r;
  logic [3:0] cursor_color_r;
  logic       cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t       cmd_in, cmd_out;
  draw_t      draw;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_glyph_r  <= 7'd33;
      cursor_color_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FIRST_GLYPH) begin
        first_glyph_r <= cfg_data;
      end else if (cfg_index == CFG_CURSOR_COL) begin
        cursor_color_r <= cfg_data[3:0];
      end
    end
  end

  tlgl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .req_type    (in_req_type),
    .table_slot  (in_table_slot),
    .slot_width  (in_slot_width),
    .char_code   (in_char_code),
    .start_x     (in_start_x),
    .start_y     (in_start_y),
    .line_color  (in_line_color),
    .want_cursor (in_want_cursor),
    .first_glyph (first_glyph_r),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  tlgl_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_out)
  );

  tlgl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_empty    (cmd_empty),
    .cmd          (cmd_out),
    .cmd_pop      (cmd_pop),
    .cursor_color (cursor_color_r),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_draw     (draw)
  );

  assign out_draw_x     = draw.draw_x;
  assign out_draw_y     = draw.draw_y;
  assign out_glyph_slot = draw.glyph_slot;
  assign out_draw_color = draw.draw_color;
  assign out_is_cursor  = draw.is_cursor;

endmodule

// File: tb/tb_text_line_glyph_layout.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_line_glyph_layout: a layout predictor tracks pen,
// colour, escape and stop state plus the glyph width table, and every draw command
// popped from the block is compared with it. Depends on tlgl_pkg and the block's RTL.
module tb_text_line_glyph_layout;
  import tlgl_pkg::*;

  localparam int TAB_STOP       = 80;
  localparam int SETTLE_CYCLES  = 10;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int PHASES         = 6;
  localparam int MAX_REPORTS    = 100;
  localparam int TIMEOUT_NS     = 400_000;

  // Register indexes beyond the list; writes to them must change nothing.
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  // One input transaction, laid out in port order.
  typedef struct packed {
    logic [1:0]  req;
    logic [6:0]  slot;
    logic [7:0]  wid;
    logic [7:0]  code;
    logic [9:0]  sx;
    logic [10:0] sy;
    logic [3:0]  col;
    logic        cur;
  } text_req_t;

  localparam int REQ_BITS = $bits(text_req_t);

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_req_type;
  logic [6:0]  in_table_slot;
  logic [7:0]  in_slot_width;
  logic [7:0]  in_char_code;
  logic [9:0]  in_start_x;
  logic [10:0] in_start_y;
  logic [3:0]  in_line_color;
  logic        in_want_cursor;
  logic        out_empty;
  logic        out_pop;
  logic [10:0] out_draw_x;
  logic [10:0] out_draw_y;
  logic [6:0]  out_glyph_slot;
  logic [3:0]  out_draw_color;
  logic        out_is_cursor;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  // Layout predictor state and its copy of the registers.
  logic [10:0] pen_x = '0;
  logic [10:0] pen_y = '0;
  logic [3:0]  pen_color = '0;
  logic        esc_armed = 1'b0;
  logic        line_halted = 1'b0;
  logic [7:0]  width_tab [GLYPH_SLOTS];
  logic [6:0]  first_char = 7'd33;
  logic [3:0]  cursor_col = 4'd0;

  draw_t pending_draws [$];
  draw_t head_draw;
  int    error_count = 0;
  int    items_sent = 0;
  logic  steady = 1'b0;

  text_line_glyph_layout dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_text_line_glyph_layout: errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    // Keep the log readable when the block is badly broken.
    if (error_count <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  function automatic logic [10:0] clamp_pen(input int v);
    return (v > int'(PEN_MAX)) ? PEN_MAX : 11'(v);
  endfunction

  // Table slot of a character: offset from the first glyph, wrapped to 7 bits.
  function automatic logic [6:0] glyph_index(input int code);
    return 7'(((code - int'(first_char)) & 127) % GLYPH_SLOTS);
  endfunction

  // Lay out one accepted transaction and queue the draw command it causes, if any.
  task automatic advance_pen(input text_req_t r);
    int code;
    int span;
    logic [6:0] gi;
    case (r.req)
      REQ_LOAD: begin
        if (int'(r.slot) < GLYPH_SLOTS) width_tab[r.slot] = r.wid;
      end
      REQ_START: begin
        pen_x = 11'(r.sx);
        pen_y = r.sy;
        pen_color = r.col;
        esc_armed = 1'b0;
        line_halted = 1'b0;
      end
      REQ_END: begin
        // The cursor fit test applies even on a stopped line.
        gi = glyph_index(int'(CH_CURSOR));
        esc_armed = 1'b0;
        if (r.cur && int'(pen_x) + int'(width_tab[gi]) <= LINE_WIDTH)
          pending_draws.push_back({pen_x, pen_y, gi, cursor_col, 1'b1});
      end
      REQ_CHAR: begin
        if (!line_halted) begin
          code = int'(r.code);
          if (esc_armed) begin
            // The byte after an escape is always consumed; only digits set the colour.
            esc_armed = 1'b0;
            if (code >= CH_ZERO && code <= CH_NINE) pen_color = 4'(code - CH_ZERO);
          end else begin
            if (code >= CH_LOW_A && code <= CH_LOW_Z) code -= CH_CASE;
            if (code == CH_NEWLINE) begin
              pen_x = '0;
              pen_y = clamp_pen(int'(pen_y) + int'(LINE_STEP));
            end else if (code == CH_TAB) begin
              span = int'(pen_x);
              pen_x = clamp_pen(span - span % TAB_STOP + TAB_STOP);
            end else if (code == CH_ESC) begin
              esc_armed = 1'b1;
            end else if (code != CH_SPACE && code >= int'(first_char) && code <= CH_LAST) begin
              gi = glyph_index(code);
              span = int'(pen_x) + int'(width_tab[gi]);
              if (span > LINE_WIDTH) begin
                line_halted = 1'b1;
              end else begin
                pending_draws.push_back({pen_x, pen_y, gi, pen_color, 1'b0});
                pen_x = clamp_pen(span);
              end
            end else begin
              pen_x = clamp_pen(int'(pen_x) + int'(BLANK_STEP));
              if (int'(pen_x) >= LINE_WIDTH) line_halted = 1'b1;
            end
          end
        end
      end
    endcase
  endtask

  // Result checking first, then register writes and new transactions, all on
  // values sampled at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_draws.size() == 0) begin
        report_mismatch("draw command with nothing expected");
      end else begin
        head_draw = pending_draws.pop_front();
        check_field("draw_x", out_draw_x, head_draw.draw_x);
        check_field("draw_y", out_draw_y, head_draw.draw_y);
        check_field("glyph_slot", out_glyph_slot, head_draw.glyph_slot);
        check_field("draw_color", out_draw_color, head_draw.draw_color);
        check_field("is_cursor", out_is_cursor, head_draw.is_cursor);
      end
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_GLYPH: first_char = cfg_data;
        CFG_CURSOR_COL:  cursor_col = cfg_data[3:0];
        default: ;
      endcase
    end
    if (rst_n && in_push && !in_full)
      advance_pen({in_req_type, in_table_slot, in_slot_width, in_char_code,
                   in_start_x, in_start_y, in_line_color, in_want_cursor});
  end

  // Result side: pops at random, or every cycle during a steady phase.
  always @(posedge clk) begin
    out_pop <= rst_n && (steady || $urandom_range(99) >= 35);
  end

  // Send one transaction, with random idle cycles ahead of it.
  task automatic send_req(input text_req_t r);
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
    end
    in_push        <= 1'b1;
    in_req_type    <= r.req;
    in_table_slot  <= r.slot;
    in_slot_width  <= r.wid;
    in_char_code   <= r.code;
    in_start_x     <= r.sx;
    in_start_y     <= r.sy;
    in_line_color  <= r.col;
    in_want_cursor <= r.cur;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  // Fields that a request kind does not use carry random values.
  function automatic text_req_t random_req();
    return REQ_BITS'({$urandom, $urandom});
  endfunction

  task automatic load_width(input logic [6:0] slot, input logic [7:0] wid);
    text_req_t r = random_req();
    r.req = REQ_LOAD;
    r.slot = slot;
    r.wid = wid;
    send_req(r);
  endtask

  task automatic start_line(input logic [9:0] sx, input logic [10:0] sy, input logic [3:0] col);
    text_req_t r = random_req();
    r.req = REQ_START;
    r.sx = sx;
    r.sy = sy;
    r.col = col;
    send_req(r);
  endtask

  task automatic put_char(input logic [7:0] code);
    text_req_t r = random_req();
    r.req = REQ_CHAR;
    r.code = code;
    send_req(r);
  endtask

  task automatic end_line(input logic cur);
    text_req_t r = random_req();
    r.req = REQ_END;
    r.cur = cur;
    send_req(r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected draw has been popped and the pipeline is quiet.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Text bytes weighted toward printable glyphs, with every special kind mixed in.
  function automatic logic [7:0] pick_text_byte();
    int roll = $urandom_range(99);
    if (roll < 55) return 8'($urandom_range(8'h21, 8'h7E));
    if (roll < 65) return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
    if (roll < 72) return CH_SPACE;
    if (roll < 76) return CH_TAB;
    if (roll < 79) return CH_NEWLINE;
    if (roll < 85) return CH_ESC;
    if (roll < 92) return 8'($urandom_range(0, 8'h20));
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  // Every slot gets a width so no read ever hits an unwritten entry.
  task automatic test_fill_widths();
    for (int s = 0; s < GLYPH_SLOTS; s++) begin
      if (s == 0) load_width(7'(s), 8'd0);
      else if (s == int'("~") - 33) load_width(7'(s), 8'hFF);
      else load_width(7'(s), 8'($urandom_range(3, 12)));
    end
  endtask

  // Each character kind at least once, with the reset register values.
  task automatic test_text_kinds();
    put_char("Z");                 // no line started yet: pen from reset
    start_line(10'd0, 11'd0, 4'd5);
    put_char("A");
    put_char("a");                 // upper-cased to the same glyph
    put_char("!");                 // zero width glyph
    put_char(CH_SPACE);
    put_char(8'h00);               // below the first glyph
    put_char(8'hFF);               // above 127
    put_char(CH_TAB);
    put_char(CH_NEWLINE);
    put_char(CH_ESC);
    put_char("7");                 // colour digit
    put_char("B");
    put_char(CH_ESC);
    put_char("x");                 // dropped after escape
    put_char(CH_ESC);
    put_char(CH_ESC);              // second escape is consumed, not armed
    put_char("C");
    put_char("~");                 // widest glyph still fits
    put_char("~");                 // this one stops the line
    put_char("D");                 // ignored on a stopped line
    end_line(1'b1);                // cursor on a stopped line
    end_line(1'b0);
  endtask

  // Pen limits: y saturation on newline and a cursor that does not fit.
  task automatic test_pen_limits();
    start_line(10'd1023, 11'd2047, 4'd15);
    put_char(CH_NEWLINE);
    end_line(1'b1);
    start_line(10'd318, 11'd100, 4'd3);
    end_line(1'b1);
  endtask

  task automatic send_noise(input int count);
    text_req_t r;
    repeat (count) begin
      r = random_req();
      if (r.req == REQ_LOAD && $urandom_range(9) < 8) r.wid = 8'($urandom_range(0, 16));
      send_req(r);
    end
  endtask

  // One random line: mostly well formed, some tab runs into saturation, some noise.
  task automatic lay_random_line();
    int kind = $urandom_range(99);
    logic [7:0] b;
    if (kind < 10) begin
      start_line(10'($urandom_range(900, 1023)), 11'($urandom), 4'($urandom));
      repeat (16) put_char(CH_TAB);
      put_char(pick_text_byte());
      end_line(1'($urandom));
    end else if (kind < 22) begin
      send_noise($urandom_range(1, 6));
    end else begin
      start_line(($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 120)),
                 ($urandom_range(3) == 0) ? 11'($urandom_range(2030, 2047)) : 11'($urandom),
                 4'($urandom));
      repeat ($urandom_range(1, 40)) begin
        b = pick_text_byte();
        put_char(b);
        if (b == CH_ESC)
          put_char(($urandom_range(9) < 7) ? 8'(CH_ZERO + $urandom_range(0, 9)) : 8'($urandom));
      end
      if ($urandom_range(9) < 8) end_line(1'($urandom));
    end
  endtask

  // Random lines under several register settings, extremes included.
  task automatic test_random_phases();
    logic [6:0] first_pick;
    int goal;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      steady <= (ph == 2);
      case (ph)
        0: first_pick = 7'd33;
        1: first_pick = 7'd0;
        2: first_pick = 7'd96;     // cursor index wraps below the first glyph
        3: first_pick = 7'd127;
        4: first_pick = 7'($urandom);
        default: first_pick = 7'd65;
      endcase
      write_reg(CFG_FIRST_GLYPH, first_pick);
      write_reg(CFG_CURSOR_COL, (ph == 0) ? 7'd0 : (ph == 1) ? 7'h7F : 7'($urandom));
      if (ph == 0) begin
        write_reg(CFG_SPARE_2, 7'($urandom));
        write_reg(CFG_SPARE_3, 7'($urandom));
      end
      repeat (6) begin
        load_width(7'($urandom),
                   ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2, 14)));
      end
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) lay_random_line();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_req_type    = REQ_LOAD;
    in_table_slot  = '0;
    in_slot_width  = '0;
    in_char_code   = '0;
    in_start_x     = '0;
    in_start_y     = '0;
    in_line_color  = '0;
    in_want_cursor = 1'b0;
    out_pop        = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_FIRST_GLYPH;
    cfg_data       = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_fill_widths();
    test_text_kinds();
    test_pen_limits();
    test_random_phases();
    settle();

    if (error_count == 0) begin
      $display("tb_text_line_glyph_layout: clean");
    end else begin
      $display("tb_text_line_glyph_layout: errors");
    end
    $finish;
  end

endmodule
